>>> rtl/fdpr_pkg.sv
// ---------------------------------------------------------------------------
// fdpr_pkg: shared types and half-precision arithmetic
// Holds the binary16 constants, the fused multiply-add function used by the
// accumulate and output stages, and the clamp helper used by the output stage.
// ---------------------------------------------------------------------------
package fdpr_pkg;

    localparam logic [15:0] H_QNAN = 16'h7E00;
    localparam logic [15:0] H_INF  = 16'h7C00;
    localparam logic [15:0] H_SIX  = 16'h4600;
    localparam logic [15:0] H_ONE  = 16'h3C00;
    localparam logic [15:0] H_ZERO = 16'h0000;

    localparam logic [1:0] REG_ACT_MODE    = 2'd0;
    localparam logic [1:0] REG_BIAS_ENABLE = 2'd1;
    localparam logic [1:0] REG_RAW_MODE    = 2'd2;

    // Finished sum handed from the accumulator to the output stage.
    typedef struct packed {
        logic        valid;
        logic [15:0] sum;
        logic [15:0] bias;
    } fin_t;

    function automatic logic h_is_nan(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic logic h_is_inf(input logic [15:0] h);
        return h[14:0] == 15'h7C00;
    endfunction

    function automatic logic h_is_zero(input logic [15:0] h);
        return h[14:0] == 15'd0;
    endfunction

    // c + a*b with the exact product and one round to nearest even.
    // The sum is formed in a fixed-point frame with its LSB at 2^-27; product
    // bits below that frame are folded into a sticky LSB, which keeps every
    // rounding decision exact. Products of 2^17 or more always overflow.
    function automatic logic [15:0] h_fma(input logic [15:0] c,
                                          input logic [15:0] a,
                                          input logic [15:0] b);
        logic        psign;
        logic [4:0]  ea, eb, ec;
        logic [10:0] ma, mb, mc;
        logic [21:0] p;
        logic [5:0]  esh;
        logic [79:0] x;
        logic [45:0] pm, cm, s;
        logic        rsign;
        logic [5:0]  k;
        logic [5:0]  qb;
        logic [45:0] shf;
        logic [12:0] r;
        logic        guard, stk;
        logic [17:0] bits;
        psign = a[15] ^ b[15];
        if (h_is_nan(a) || h_is_nan(b) || h_is_nan(c))
            return H_QNAN;
        if (h_is_inf(a) || h_is_inf(b)) begin
            if (h_is_zero(a) || h_is_zero(b))
                return H_QNAN;
            if (h_is_inf(c) && (c[15] != psign))
                return H_QNAN;
            return {psign, H_INF[14:0]};
        end
        if (h_is_inf(c))
            return c;

        ea = (a[14:10] == 5'd0) ? 5'd1 : a[14:10];
        eb = (b[14:10] == 5'd0) ? 5'd1 : b[14:10];
        ec = (c[14:10] == 5'd0) ? 5'd1 : c[14:10];
        ma = {a[14:10] != 5'd0, a[9:0]};
        mb = {b[14:10] != 5'd0, b[9:0]};
        mc = {c[14:10] != 5'd0, c[9:0]};
        p  = ma * mb;
        esh = {1'b0, ea} + {1'b0, eb} - 6'd2;
        x  = {58'd0, p} << esh;
        if (|x[79:66])
            return {psign, H_INF[14:0]};
        pm = {1'b0, x[65:22], x[21] | (|x[20:0])};
        cm = {35'd0, mc} << ({1'b0, ec} + 6'd2);

        if (psign == c[15]) begin
            s = pm + cm;
            rsign = c[15];
        end else if (pm > cm) begin
            s = pm - cm;
            rsign = psign;
        end else if (cm > pm) begin
            s = cm - pm;
            rsign = c[15];
        end else begin
            s = 46'd0;
            rsign = 1'b0;
        end
        if (s == 46'd0)
            return {rsign, 15'd0};

        k = 6'd0;
        for (int i = 0; i < 46; i++) begin
            if (s[i])
                k = 6'(i);
        end
        qb = (k < 6'd13) ? 6'd3 : (k - 6'd10);
        shf = s >> qb;
        r = shf[12:0];
        shf = s >> (qb - 6'd1);
        guard = shf[0];
        stk = |(s & ((46'd1 << (qb - 6'd1)) - 46'd1));
        if (guard && (stk || r[0]))
            r = r + 13'd1;
        if (k < 6'd13)
            bits = {5'd0, r};
        else
            bits = ({12'd0, k - 6'd12} << 10) + {5'd0, r} - 18'd1024;
        if (bits >= {2'd0, H_INF})
            bits = {2'd0, H_INF};
        return {rsign, bits[14:0]};
    endfunction

    function automatic logic [15:0] clamp_low(input logic [15:0] h);
        if (!h_is_nan(h) && h[15] && !h_is_zero(h))
            return H_ZERO;
        return h;
    endfunction

endpackage

>>> rtl/fdpr_mac.sv
// ---------------------------------------------------------------------------
// fdpr_mac: half-precision multiply-accumulate stage
// Folds each accepted term into the running sum; on the last term it hands
// the finished sum and bias on and clears the sum.
// ---------------------------------------------------------------------------
module fdpr_mac
    import fdpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_act_value,
    input  logic [15:0] s_weight_value,
    input  logic [15:0] s_bias_value,
    input  logic        s_last_term,
    output fin_t        fin,
    input  logic        fin_ready
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    fin_t        fin_reg;
    logic        take;

    assign s_ready  = !fin_reg.valid || fin_ready;
    assign take     = s_valid && s_ready;
    assign sum_next = h_fma(sum_reg, s_act_value, s_weight_value);
    assign fin      = fin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= H_ZERO;
            fin_reg.valid <= 1'b0;
        end else begin
            if (fin_ready)
                fin_reg.valid <= 1'b0;
            if (take) begin
                sum_reg <= s_last_term ? H_ZERO : sum_next;
                if (s_last_term) begin
                    fin_reg.valid <= 1'b1;
                    fin_reg.sum   <= sum_next;
                    fin_reg.bias  <= s_bias_value;
                end
            end
        end
    end

endmodule

>>> rtl/fdpr_post.sv
// ---------------------------------------------------------------------------
// fdpr_post: bias and activation output stage
// Bias if enabled, clamp per act_mode, or raw sum; result held for transfer.
// ---------------------------------------------------------------------------
module fdpr_post
    import fdpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fin_t        fin,
    output logic        fin_ready,
    input  logic [1:0]  act_mode,
    input  logic        bias_enable,
    input  logic        raw_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_value
);

    logic        valid_reg;
    logic [15:0] res_reg;
    logic [15:0] biased;
    logic [15:0] res_next;

    assign fin_ready = !valid_reg || m_ready;
    assign biased    = bias_enable ? h_fma(fin.sum, fin.bias, H_ONE) : fin.sum;

    always_comb begin
        res_next = biased;
        if (raw_mode) begin
            res_next = fin.sum;
        end else if (act_mode[0]) begin
            res_next = clamp_low(biased);
        end else if (act_mode[1]) begin
            res_next = clamp_low(biased);
            if (!h_is_nan(res_next) && !res_next[15] && (res_next > H_SIX))
                res_next = H_SIX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (fin_ready) begin
            valid_reg <= fin.valid;
            if (fin.valid)
                res_reg <= res_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_result_value = res_reg;

endmodule

>>> rtl/fp16_dot_product_relu_core.sv
// ---------------------------------------------------------------------------
// fp16_dot_product_relu_core: half-precision dot product with ReLU/ReLU6
// Accumulates activation*weight terms with one rounding per term, then on
// the last term adds any enabled bias and clamp (raw mode: the plain sum).
// ---------------------------------------------------------------------------
//  Channel  | Ports                                   | Direction
//  ---------+-----------------------------------------+----------
//  input    | s_valid/s_ready, s_act_value, s_weight_value,
//           | s_bias_value, s_last_term               | in
//  result   | m_valid/m_ready, m_result_value         | out
//  config   | cfg_wr_en, cfg_index, cfg_wdata         | in
//
// One term is accepted every cycle while s_ready is high; the fused
// multiply-add that updates the running sum completes in the cycle of the transfer.
// A result passes from its last term into the finish register, then through
// the bias/clamp logic into the output register.
// Reset clears the running sum to +0 and loads the register defaults
// (act_mode 0, bias_enable 1, raw_mode 0).
// When the output register holds an untaken result, the finish register
// fills next, and only then does s_ready drop.
// ---------------------------------------------------------------------------
module fp16_dot_product_relu_core
    import fdpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_act_value,
    input  logic [15:0] s_weight_value,
    input  logic [15:0] s_bias_value,
    input  logic        s_last_term,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_result_value,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_wdata
);

    logic [1:0] act_mode_reg;
    logic       bias_enable_reg;
    logic       raw_mode_reg;
    fin_t       fin;
    logic       fin_ready;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_mode_reg    <= 2'd0;
            bias_enable_reg <= 1'b1;
            raw_mode_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ACT_MODE:    act_mode_reg    <= cfg_wdata;
                REG_BIAS_ENABLE: bias_enable_reg <= cfg_wdata[0];
                REG_RAW_MODE:    raw_mode_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Accumulator: owns the running sum and the finish register.
    fdpr_mac u_mac (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_act_value    (s_act_value),
        .s_weight_value (s_weight_value),
        .s_bias_value   (s_bias_value),
        .s_last_term    (s_last_term),
        .fin            (fin),
        .fin_ready      (fin_ready)
    );

    // Output stage: bias, activation clamp and the output register.
    fdpr_post u_post (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .fin            (fin),
        .fin_ready      (fin_ready),
        .act_mode       (act_mode_reg),
        .bias_enable    (bias_enable_reg),
        .raw_mode       (raw_mode_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value)
    );

    // Every NaN that leaves the block is the canonical quiet NaN.
    a_canonical_nan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_value[14:10] == 5'h1F) && (m_result_value[9:0] != 10'd0))
        |-> (m_result_value == H_QNAN))
        else $error("non-canonical NaN on result");

    // ReLU6 results never exceed six; negative zero passes the clamp.
    a_relu6_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !raw_mode_reg && (act_mode_reg == 2'd2))
        |-> ((m_result_value <= H_SIX) || (m_result_value == H_QNAN) ||
             h_is_zero(m_result_value)))
        else $error("ReLU6 result above six");

    // With a ReLU clamp active, no negative nonzero value is emitted.
    a_relu_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !raw_mode_reg && (act_mode_reg != 2'd0))
        |-> (!m_result_value[15] || (m_result_value[14:0] == 15'd0)))
        else $error("negative result with ReLU active");

endmodule
